### src/hcs_pkg.sv
// Shared types and constants for the Hamiltonian cycle search block.
package hcs_pkg;

	localparam int MAX_VERTICES_DEF = 16;

	localparam int VC_W   = 5;
	localparam int IDX_W  = 4;
	localparam int ROW_W  = 16;
	localparam int VERT_W = 4;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
	localparam logic [VC_W-1:0]    VC_RESET          = 5'd16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_POP,
		ST_NF,
		ST_OUT_RD,
		ST_OUT_LD
	} hcs_state_t;

endpackage

### src/hamiltonian_cycle_search_top.sv
// Hamiltonian cycle search: row loads, depth-first backtracking, cycle readout.
// A load word writes its row in idle. A start word runs a search: an advance is an
// EVAL step and a backtrack step is POP then EVAL, set by the single adjacency and
// path stack read ports. Each result word is a stack read, then an output load.
// No input is taken from a start until its last result is in the output register.
// Reset (arst_n, async): idle, empty output register, vertex count 16; no memory clear.
module hamiltonian_cycle_search_top import hcs_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [IDX_W-1:0]   row_index,
	input  logic [ROW_W-1:0]   row_edges,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [VERT_W-1:0]  vertex,
	output logic               last
);

	logic [VC_W-1:0] vertex_count;

	hcs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_count (vertex_count)
	);

	hcs_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_count (vertex_count),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.row_index    (row_index),
		.row_edges    (row_edges),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.vertex       (vertex),
		.last         (last)
	);

endmodule

### src/hcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/hcs_cfg.sv
// APB register file holding the vertex count.
module hcs_cfg import hcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [VC_W-1:0]    vertex_count
);

	logic [VC_W-1:0] vertex_count_q;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (wr_en && paddr == ADDR_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[VC_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_VERTEX_COUNT: prdata = PDATA_W'(vertex_count_q);
			default:           prdata = '0;
		endcase
	end

	assign vertex_count = vertex_count_q;

endmodule

### src/hcs_ctrl.sv
// Backtracking search sequencer around the adjacency and path stack memories.
module hcs_ctrl import hcs_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VC_W-1:0]   vertex_count,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [ROW_W-1:0]  row_edges,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [VERT_W-1:0] vertex,
	output logic              last
);

	localparam int VLIMIT = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
	localparam int AW     = $clog2(VLIMIT);
	localparam int LW     = $clog2(VLIMIT + 1);

	hcs_state_t state_q, state_d;

	logic [LW-1:0]     level_q, level_d;
	logic [LW-1:0]     next_q, next_d;
	logic [LW-1:0]     n_q, n_d;
	logic [LW-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]     top_q, top_d;
	logic [VLIMIT-1:0] vis_q, vis_d;

	logic              out_valid_q;
	logic              found_q;
	logic [VERT_W-1:0] vertex_q;
	logic              last_q;
	logic              out_load;
	logic              out_found;
	logic [VERT_W-1:0] out_vertex;
	logic              out_last;
	logic              out_free;

	logic              adj_we, adj_re;
	logic [AW-1:0]     adj_waddr, adj_raddr;
	logic [ROW_W-1:0]  adj_rdata;
	logic              stk_we, stk_re;
	logic [AW-1:0]     stk_waddr, stk_raddr, stk_wdata;
	logic [AW-1:0]     stk_rdata;

	logic [LW-1:0]     n_start;
	logic [VLIMIT-1:0] cand;
	logic [AW-1:0]     pick;
	logic              in_acc;

	hcs_ram #(.WIDTH(ROW_W), .DEPTH(VLIMIT)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (row_edges),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	hcs_ram #(.WIDTH(AW), .DEPTH(VLIMIT)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// vertex count clamped to 1..VLIMIT
	always_comb begin
		if (vertex_count == '0) begin
			n_start = LW'(1);
		end else if (vertex_count > VC_W'(VLIMIT)) begin
			n_start = LW'(VLIMIT);
		end else begin
			n_start = LW'(vertex_count);
		end
	end

	// unvisited neighbors of the path top at or after the resume point, lowest first
	always_comb begin
		for (int i = 0; i < VLIMIT; i++) begin
			cand[i] = adj_rdata[i] && !vis_q[i] && (LW'(i) >= next_q) && (LW'(i) < n_q);
		end
		pick = '0;
		for (int i = VLIMIT - 1; i >= 0; i--) begin
			if (cand[i]) begin
				pick = AW'(i);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		level_d    = level_q;
		next_d     = next_q;
		n_d        = n_q;
		cnt_d      = cnt_q;
		top_d      = top_q;
		vis_d      = vis_q;
		adj_we     = 1'b0;
		adj_waddr  = row_index[AW-1:0];
		adj_re     = 1'b0;
		adj_raddr  = top_q;
		stk_we     = 1'b0;
		stk_waddr  = level_q[AW-1:0];
		stk_wdata  = pick;
		stk_re     = 1'b0;
		stk_raddr  = '0;
		out_load   = 1'b0;
		out_found  = 1'b0;
		out_vertex = '0;
		out_last   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (op == OP_LOAD) begin
						adj_we = ({1'b0, row_index} < (IDX_W + 1)'(VLIMIT));
					end else begin
						// path starts at vertex 0
						stk_we    = 1'b1;
						stk_waddr = '0;
						stk_wdata = '0;
						adj_re    = 1'b1;
						adj_raddr = '0;
						top_d     = '0;
						vis_d     = VLIMIT'(1);
						level_d   = LW'(1);
						next_d    = LW'(1);
						n_d       = n_start;
						state_d   = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				if (level_q < n_q && cand != '0) begin
					stk_we    = 1'b1;
					stk_waddr = level_q[AW-1:0];
					stk_wdata = pick;
					vis_d     = vis_q | (VLIMIT'(1) << pick);
					level_d   = level_q + LW'(1);
					next_d    = LW'(1);
					top_d     = pick;
					adj_re    = 1'b1;
					adj_raddr = pick;
				end else if (level_q >= n_q && adj_rdata[0]) begin
					cnt_d   = '0;
					state_d = ST_OUT_RD;
				end else begin
					level_d = level_q - LW'(1);
					if (level_q == LW'(1)) begin
						vis_d   = '0;
						state_d = ST_NF;
					end else begin
						// drop the top and fetch the vertex below it
						vis_d     = vis_q & ~(VLIMIT'(1) << top_q);
						next_d    = LW'(top_q) + LW'(1);
						stk_re    = 1'b1;
						stk_raddr = AW'(level_q - LW'(2));
						state_d   = ST_POP;
					end
				end
			end
			ST_POP: begin
				top_d     = stk_rdata;
				adj_re    = 1'b1;
				adj_raddr = stk_rdata;
				state_d   = ST_EVAL;
			end
			ST_NF: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_OUT_RD: begin
				stk_re    = 1'b1;
				stk_raddr = (cnt_q == n_q) ? '0 : cnt_q[AW-1:0];
				state_d   = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_found  = 1'b1;
					out_vertex = VERT_W'(stk_rdata);
					out_last   = (cnt_q == n_q);
					cnt_d      = cnt_q + LW'(1);
					state_d    = (cnt_q == n_q) ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			next_q      <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			top_q       <= '0;
			vis_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			next_q  <= next_d;
			n_q     <= n_d;
			cnt_q   <= cnt_d;
			top_q   <= top_d;
			vis_q   <= vis_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q  <= out_found;
			vertex_q <= out_vertex;
			last_q   <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign vertex    = vertex_q;
	assign last      = last_q;

	// path length and visited set stay in step
	a_vis_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $countones(vis_q) == int'(level_q))
		else $error("visited mask out of step with search level");

	a_root_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> vis_q[0] && level_q != '0 && level_q <= n_q)
		else $error("search level or root mark corrupt");

	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_NF || state_q == ST_OUT_LD))
		else $error("result word loaded outside output states");

	a_nf_word: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_NF && out_free) |-> out_valid_q && last_q && !found_q)
		else $error("not-found word malformed");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |=> state_q == ST_EVAL)
		else $error("pop did not return to evaluation");

endmodule
